### sv/track_angle_running_statistics_defines.svh
// Assertion macros for the track angle statistics block.
// Used by the top level only; expects clk and rst in scope.
`ifndef TRACK_ANGLE_RUNNING_STATISTICS_DEFINES_SVH
`define TRACK_ANGLE_RUNNING_STATISTICS_DEFINES_SVH

// Same-cycle implication, idle during reset
`define TARS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle during reset
`define TARS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tars_pkg.sv
// Shared types and constants for the track angle statistics block.
// No dependencies; imported by every module of the block.
package tars_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int MAX_NODES_DEF = 63;
  localparam int COUNT_OUT_W   = 6;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCATTER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP     = 2'd2;

  // reset values: 0.04, 0.0001 and 0.4 rad in Q0.16
  localparam logic [CFG_W-1:0] SCATTER_RST  = 16'd2621;
  localparam logic [CFG_W-1:0] MIN_TEST_RST = 16'd7;
  localparam logic [CFG_W-1:0] KEEP_RST     = 16'd26214;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] angle;
    logic                  restart;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] node_count;
    logic [ANGLE_BITS-1:0]  mean_angle;
    logic [ANGLE_BITS-1:0]  rms_angle;
    logic [ANGLE_BITS-1:0]  test_angle;
    logic                   keep_link;
  } out_item_t;

  // per-unit sequencing: load operands, or advance one bit
  typedef struct packed {
    logic load;
    logic step;
  } unit_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROOT,
    ST_DIV,
    ST_DONE
  } tars_state_t;

endpackage

### sv/tars_mac.sv
// Bit-serial shift-and-add multiply-accumulate: one multiplier bit a cycle while step is high.
// Depends on tars_pkg (unit_ctrl_t).
module tars_mac #(
  parameter int MCAND_W = 16,
  parameter int MPL_W   = 16,
  parameter int ACC_W   = 38
) (
  input  logic                 clk,
  input  tars_pkg::unit_ctrl_t ctrl,
  input  logic [ACC_W-1:0]     init_acc,
  input  logic [MCAND_W-1:0]   mcand,
  input  logic [MPL_W-1:0]     mplier,
  output logic [ACC_W-1:0]     acc
);
  import tars_pkg::*;

  logic [ACC_W-1:0] mcand_sh;
  logic [MPL_W-1:0] mpl_sh;
  logic [ACC_W-1:0] acc_reg;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc_reg  <= init_acc;
      mcand_sh <= ACC_W'(mcand);
      mpl_sh   <= mplier;
    end else if (ctrl.step) begin
      if (mpl_sh[0]) begin
        acc_reg <= acc_reg + mcand_sh;
      end
      mcand_sh <= mcand_sh << 1;
      mpl_sh   <= mpl_sh >> 1;
    end
  end

  assign acc = acc_reg;

endmodule

### sv/tars_div.sv
// Restoring divider, one quotient bit a cycle while step is high, MSB first; N_W steps.
// Depends on tars_pkg (unit_ctrl_t). Shared by mean and RMS scaling.
module tars_div #(
  parameter int N_W = 22,
  parameter int D_W = 6
) (
  input  logic                 clk,
  input  tars_pkg::unit_ctrl_t ctrl,
  input  logic [N_W-1:0]       dividend,
  input  logic [D_W-1:0]       divisor,
  output logic [N_W-1:0]       quot
);
  import tars_pkg::*;

  logic [N_W-1:0] quo_sh;
  logic [D_W-1:0] rem;
  logic [D_W-1:0] dvs;
  logic [D_W:0]   trial;
  logic           fits;

  always_comb begin
    trial = {rem, quo_sh[N_W-1]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      quo_sh <= dividend;
      rem    <= '0;
      dvs    <= divisor;
    end else if (ctrl.step) begin
      if (fits) begin
        rem <= D_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[D_W-1:0];
      end
      quo_sh <= {quo_sh[N_W-2:0], fits};
    end
  end

  assign quot = quo_sh;

endmodule

### sv/tars_sqrt.sv
// Integer square root, two radicand bits in and one root bit out a cycle while step is high.
// Depends on tars_pkg (unit_ctrl_t). IN_W must be even; IN_W/2 steps.
module tars_sqrt #(
  parameter int IN_W = 44
) (
  input  logic                 clk,
  input  tars_pkg::unit_ctrl_t ctrl,
  input  logic [IN_W-1:0]      radicand,
  output logic [IN_W/2-1:0]    root
);
  import tars_pkg::*;

  localparam int ROOT_W = IN_W / 2;

  logic [IN_W-1:0]   x_sh;
  logic [ROOT_W+1:0] rem;
  logic [ROOT_W-1:0] root_reg;
  logic [ROOT_W+3:0] rem_sh;
  logic [ROOT_W+3:0] trial;
  logic              fits;

  always_comb begin
    rem_sh = {rem, x_sh[IN_W-1 -: 2]};
    trial  = {2'b00, root_reg, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_sh     <= radicand;
      rem      <= '0;
      root_reg <= '0;
    end else if (ctrl.step) begin
      if (fits) begin
        rem <= (ROOT_W + 2)'(rem_sh - trial);
      end else begin
        rem <= rem_sh[ROOT_W+1:0];
      end
      root_reg <= {root_reg[ROOT_W-2:0], fits};
      x_sh     <= x_sh << 2;
    end
  end

  assign root = root_reg;

endmodule

### sv/track_angle_running_statistics.sv
// Running mean and RMS spread of link angles along a track.
// Top level: sequencer, accumulators, registers, output stage.
// Depends on tars_pkg, tars_mac, tars_div, tars_sqrt and the defines header.
//
// Use: an item on in_data (angle, restart) is taken when in_valid is high and
// in_stall low. restart begins a new track before the angle is added. Each
// item gives exactly one result item on out_data (count, mean, RMS spread,
// test angle, keep flag), held under out_valid until out_stall is low.
// One item is worked on at a time; in_stall is high from the accepting edge
// until the result has been moved into the output register.
// Three bit-serial passes set the time per item: the shift and add products,
// the root extraction and the shared divider; after the accepting edge the
// item goes through the product, root and divide states, and the result is
// registered from the done state. A result waiting under out_stall does not
// block the next item: only a second finished result waits in the last state
// for the register to free. Reset (rst, synchronous) empties the accumulators,
// returns the registers to their defaults and drops out_valid. Registers are
// written by cfg_write / cfg_index / cfg_data; the user must write them only
// while idle, the block does not enforce it. Indexes past the list are ignored.
`include "track_angle_running_statistics_defines.svh"

module track_angle_running_statistics #(
  parameter int MAX_NODES = tars_pkg::MAX_NODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tars_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tars_pkg::out_item_t            out_data,
  input  logic                           cfg_write,
  input  logic [tars_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tars_pkg::CFG_W-1:0]     cfg_data
);
  import tars_pkg::*;

  // count, sum, sum of squares, n*S2 and S1^2 widths
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int SUM_W  = ANGLE_BITS + CNT_W;
  localparam int SQ_W   = 2 * ANGLE_BITS + CNT_W;
  localparam int P_W    = 2 * SUM_W;
  localparam int ROOT_W = P_W / 2;
  localparam int PH_W   = $clog2(SUM_W + 1);

  localparam logic [PH_W-1:0] PH_SQ_END   = PH_W'(ANGLE_BITS);
  localparam logic [PH_W-1:0] PH_MUL_END  = PH_W'(SUM_W);
  localparam logic [PH_W-1:0] PH_ROOT_END = PH_W'(ROOT_W);
  localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_NODES);
  localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO    = CNT_W'(2);

  tars_state_t state, state_next;
  logic [PH_W-1:0] ph;

  // configuration
  logic [CFG_W-1:0] scatter_angle;
  logic [CFG_W-1:0] min_test_angle;
  logic [CFG_W-1:0] keep_limit;

  // track state
  logic [CNT_W-1:0] count_reg;
  logic [SUM_W-1:0] sum_reg;
  logic [SQ_W-1:0]  sum_sq_reg;
  logic             keep_reg;
  logic [ANGLE_BITS-1:0] mean_reg;

  // accept-time values
  logic             in_accept;
  logic [CNT_W-1:0] count_base, count_next;
  logic [SUM_W-1:0] sum_next;
  logic [SQ_W-1:0]  sq_init;
  logic [ANGLE_BITS-1:0] sq_mplier;
  logic             acc_en;

  unit_ctrl_t sq_ctrl, p_ctrl, q_ctrl, div_ctrl, root_ctrl;
  logic [SQ_W-1:0]  sq_acc;
  logic [P_W-1:0]   p_acc, q_acc, diff;
  logic [ROOT_W-1:0] root;
  logic [SUM_W-1:0] div_dividend, div_quot;
  logic [CNT_W-1:0] div_divisor;

  logic            out_load;
  logic [ANGLE_BITS-1:0] rms, test_base, test;
  out_item_t       result;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // restart clears before the add; a full chain holds its sums
  always_comb begin
    count_base = in_data.restart ? '0 : count_reg;
    acc_en     = count_base < CNT_MAX;
    count_next = acc_en ? count_base + CNT_ONE : count_base;
    sum_next   = (in_data.restart ? '0 : sum_reg)
               + (acc_en ? SUM_W'(in_data.angle) : '0);
    sq_init    = in_data.restart ? '0 : sum_sq_reg;
    sq_mplier  = acc_en ? in_data.angle : '0;
  end

  // S2 += a*a, then p = n*S2 from the updated S2
  tars_mac #(.MCAND_W(ANGLE_BITS), .MPL_W(ANGLE_BITS), .ACC_W(SQ_W)) u_sq_mac (
    .clk(clk), .ctrl(sq_ctrl), .init_acc(sq_init),
    .mcand(in_data.angle), .mplier(sq_mplier), .acc(sq_acc)
  );

  tars_mac #(.MCAND_W(SQ_W), .MPL_W(CNT_W), .ACC_W(P_W)) u_p_mac (
    .clk(clk), .ctrl(p_ctrl), .init_acc('0),
    .mcand(sq_acc), .mplier(count_reg), .acc(p_acc)
  );

  // q = S1^2
  tars_mac #(.MCAND_W(SUM_W), .MPL_W(SUM_W), .ACC_W(P_W)) u_q_mac (
    .clk(clk), .ctrl(q_ctrl), .init_acc('0),
    .mcand(sum_next), .mplier(sum_next), .acc(q_acc)
  );

  assign diff = (p_acc > q_acc) ? p_acc - q_acc : '0;

  tars_sqrt #(.IN_W(P_W)) u_sqrt (
    .clk(clk), .ctrl(root_ctrl), .radicand(diff), .root(root)
  );

  // divider: S1/n at accept, root/(n-1) after the root pass
  assign div_dividend = (state == ST_IDLE) ? sum_next : SUM_W'(root);
  assign div_divisor  = (state == ST_IDLE) ? count_next : count_reg - CNT_ONE;

  tars_div #(.N_W(SUM_W), .D_W(CNT_W)) u_div (
    .clk(clk), .ctrl(div_ctrl), .dividend(div_dividend),
    .divisor(div_divisor), .quot(div_quot)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sq_ctrl    = '0;
    p_ctrl     = '0;
    q_ctrl     = '0;
    div_ctrl   = '0;
    root_ctrl  = '0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          sq_ctrl.load  = 1'b1;
          q_ctrl.load   = 1'b1;
          div_ctrl.load = 1'b1;
          state_next    = ST_MUL;
        end
      end
      ST_MUL: begin
        sq_ctrl.step  = ph < PH_SQ_END;
        q_ctrl.step   = ph < PH_MUL_END;
        div_ctrl.step = ph < PH_MUL_END;
        p_ctrl.load   = ph == PH_SQ_END;
        p_ctrl.step   = ph > PH_SQ_END;
        if (ph == PH_MUL_END) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        root_ctrl.load = ph == '0;
        root_ctrl.step = ph != '0;
        if (ph == PH_ROOT_END) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        div_ctrl.load = ph == '0;
        div_ctrl.step = ph != '0;
        if (ph == PH_MUL_END) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        out_load = !out_valid || !out_stall;
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // phase counter restarts on every state change
  always_ff @(posedge clk) begin
    if (rst || state_next != state) begin
      ph <= '0;
    end else begin
      ph <= ph + 1'b1;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scatter_angle  <= SCATTER_RST;
      min_test_angle <= MIN_TEST_RST;
      keep_limit     <= KEEP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SCATTER:  scatter_angle  <= cfg_data;
        CFG_MIN_TEST: min_test_angle <= cfg_data;
        CFG_KEEP:     keep_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg  <= '0;
      sum_reg    <= '0;
      sum_sq_reg <= '0;
    end else begin
      if (in_accept) begin
        count_reg <= count_next;
        sum_reg   <= sum_next;
      end
      if (state == ST_MUL && ph == PH_SQ_END) begin
        sum_sq_reg <= sq_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      keep_reg <= in_data.angle < keep_limit;
    end
    if (state == ST_MUL && ph == PH_MUL_END) begin
      mean_reg <= div_quot[ANGLE_BITS-1:0];   // S1/n never exceeds an angle
    end
  end

  // result: saturate, pick and clamp the test angle; scatter/2 when RMS exceeds scatter
  always_comb begin
    if (count_reg <= CNT_ONE) begin
      rms = '0;
    end else if (|div_quot[SUM_W-1:ANGLE_BITS]) begin
      rms = '1;
    end else begin
      rms = div_quot[ANGLE_BITS-1:0];
    end
    test_base = (count_reg > CNT_TWO) ? rms : mean_reg;
    test      = (test_base < min_test_angle) ? min_test_angle : test_base;
    if (rms > scatter_angle) begin
      test = scatter_angle >> 1;
    end
    result.node_count = COUNT_OUT_W'(count_reg);
    result.mean_angle = mean_reg;
    result.rms_angle  = rms;
    result.test_angle = test;
    result.keep_link  = keep_reg;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= result;
    end
  end

  // checks
  `TARS_ASSERT_NEXT(a_accept_starts_mul, in_valid && !in_stall, in_stall && state == ST_MUL, "accepted item did not start the product pass")
  `TARS_ASSERT_NOW(a_count_bounded, 1'b1, count_reg <= CNT_MAX, "node count above chain limit")
  `TARS_ASSERT_NEXT(a_done_delivers, state == ST_DONE && !(out_valid && out_stall), out_valid && state == ST_IDLE, "finished result not moved to output")
  `TARS_ASSERT_NOW(a_rms_ceiling, out_valid, out_data.rms_angle <= scatter_angle || out_data.test_angle == (scatter_angle >> 1), "test angle not replaced above RMS ceiling")

endmodule

### tb/sv/tb_track_angle_running_statistics.sv
`timescale 1ns / 100ps
// Self-checking testbench for track_angle_running_statistics.
// Needs tars_pkg and the block's RTL; predicts each result item on the fly.

module tb_track_angle_running_statistics;
  import tars_pkg::*;

  // spare register index, not in the list: writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int NUM_DIR      = 22;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 64;
  localparam int SQUEEZE_HOLD = 400;   // long receiver hold-off, cycles
  localparam int TAIL_CYCLES  = 100;   // wait after the last result, cycles
  localparam longint unsigned ANGLE_MAX = 64'hFFFF;

  typedef struct packed {
    in_item_t  stim;
    logic      typed;   // 1: want is written out by hand
    out_item_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  track_angle_running_statistics dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Hard stop: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor: own copy of the track accumulators and the registers
  // ---------------------------------------------------------------------
  longint unsigned trk_nodes, trk_sum, trk_sq;
  logic [CFG_W-1:0] scatter_q, min_test_q, keep_q;

  out_item_t pending_stats [$];   // expected result items, oldest first
  int        err_count = 0;

  // sides' idling: calm means no gaps at all for the phase
  bit src_calm  = 1'b0;
  bit sink_calm = 1'b0;
  bit squeeze_req = 1'b0;

  // stimulus track shaping
  int              stim_left = 0;
  longint unsigned stim_base, stim_spread;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, trial;
    int b;
    r = 0;
    for (b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  // Accumulate one angle and work out the result item it gives
  function automatic out_item_t advance_track(in_item_t it);
    longint unsigned a, n, mean, rms, test, p, q;
    out_item_t r;
    a = it.angle;
    if (it.restart) begin
      trk_nodes = 0;
      trk_sum   = 0;
      trk_sq    = 0;
    end
    // saturated chain: sums hold, new angle only judged for keep
    if (trk_nodes < MAX_NODES_DEF) begin
      trk_nodes = trk_nodes + 1;
      trk_sum   = trk_sum + a;
      trk_sq    = trk_sq + a * a;
    end
    n    = trk_nodes;
    mean = trk_sum / n;
    rms  = 0;
    if (n > 1) begin
      p = n * trk_sq;
      q = trk_sum * trk_sum;
      if (p > q) begin
        rms = root_floor(p - q) / (n - 1);
        if (rms > ANGLE_MAX) rms = ANGLE_MAX;
      end
    end
    test = (n > 2) ? rms : mean;
    if (test < min_test_q) test = min_test_q;
    if (rms > scatter_q) test = scatter_q >> 1;
    r.node_count = 6'(n);
    r.mean_angle = 16'(mean);
    r.rms_angle  = 16'(rms);
    r.test_angle = 16'(test);
    r.keep_link  = (a < keep_q);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what);
    $display("ERROR at %0t ns: %s", $time, what);
    err_count++;
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  // ---------------------------------------------------------------------
  // Driving side. Called at a falling edge, returns at a falling edge.
  // ---------------------------------------------------------------------
  task automatic offer_item(in_item_t it, logic typed, out_item_t want);
    int gap;
    out_item_t pred;
    gap = src_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge: step the predictor now
    pred = advance_track(it);
    pending_stats.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // Register write; the block is idle, so the mirror changes at once
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      CFG_SCATTER:  scatter_q  = val;
      CFG_MIN_TEST: min_test_q = val;
      CFG_KEEP:     keep_q     = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Mostly well-formed tracks (restart first, angles clustered round a
  // base), the odd long one to reach saturation, and some raw noise.
  function automatic in_item_t next_track_item();
    in_item_t it;
    longint signed v;
    if ($urandom_range(0, 7) == 0) begin
      it.angle   = 16'($urandom_range(0, 65535));
      it.restart = 1'($urandom_range(0, 1));
      return it;
    end
    it.restart = 1'b0;
    if (stim_left == 0) begin
      it.restart  = 1'b1;
      stim_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80)
                                                : $urandom_range(1, 12);
      stim_base   = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 4000);
      stim_spread = $urandom_range(0, 1 << $urandom_range(0, 12));
    end
    stim_left--;
    v = longint'(stim_base) + longint'($urandom_range(0, 2 * stim_spread))
        - longint'(stim_spread);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    it.angle = 16'(v);
    return it;
  endfunction

  function automatic dir_row_t mk_row(int angle, bit restart, bit typed,
                                      int cnt = 0, int mean = 0, int rms = 0,
                                      int test = 0, bit keep = 0);
    dir_row_t r;
    r.stim.angle      = 16'(angle);
    r.stim.restart    = restart;
    r.typed           = typed;
    r.want.node_count = 6'(cnt);
    r.want.mean_angle = 16'(mean);
    r.want.rms_angle  = 16'(rms);
    r.want.test_angle = 16'(test);
    r.want.keep_link  = keep;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Receiving side: stall drawn per result item, counted once the item
  // shows, so stalls land on results actually waiting.
  // ---------------------------------------------------------------------
  initial begin
    int hold;
    out_item_t got, want;
    wait (!rst);
    @(negedge clk);
    forever begin
      hold = sink_calm ? 0 : $urandom_range(0, 10);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold = SQUEEZE_HOLD;
      end
      out_stall = (hold > 0);
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (hold > 0) begin
        repeat (hold) @(negedge clk);
        out_stall = 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
      got = out_data;
      if (pending_stats.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = pending_stats.pop_front();
        check_field("node_count", got.node_count, want.node_count);
        check_field("mean_angle", got.mean_angle, want.mean_angle);
        check_field("rms_angle",  got.rms_angle,  want.rms_angle);
        check_field("test_angle", got.test_angle, want.test_angle);
        check_field("keep_link",  got.keep_link,  want.keep_link);
      end
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    dir_row_t  dir_rows [NUM_DIR];
    int        i, ph;
    logic [CFG_W-1:0] scat, mint, keep;
    out_item_t none;

    none = '0;
    // Directed rows at the reset settings (scatter 2621, min 7, keep 26214).
    // Hand-typed rows are plain to read off; the rest go to the predictor.
    dir_rows = '{
      // first item with no restart: zeroed accumulators start the track
      mk_row(0,     0, 1, 1, 0,     0,     7,     1),
      mk_row(65535, 1, 1, 1, 65535, 0,     65535, 0),
      // widest spread: rms at full scale, test falls to scatter/2
      mk_row(0,     0, 1, 2, 32767, 65535, 1310,  1),
      mk_row(65535, 0, 0),
      mk_row(12345, 0, 0),
      // keep limit either side
      mk_row(26213, 1, 1, 1, 26213, 0,     26213, 1),
      mk_row(26214, 1, 1, 1, 26214, 0,     26214, 0),
      // test raised to the minimum
      mk_row(3,     1, 1, 1, 3,     0,     7,     1),
      // zero variance, then rms chosen at n = 3 and clamped
      mk_row(100,   1, 1, 1, 100,   0,     100,   1),
      mk_row(100,   0, 1, 2, 100,   0,     100,   1),
      mk_row(100,   0, 1, 3, 100,   0,     7,     1),
      // modest spread below the ceiling, then an outlier above it
      mk_row(1000,  1, 0),
      mk_row(1200,  0, 0),
      mk_row(900,   0, 0),
      mk_row(1100,  0, 0),
      mk_row(1050,  0, 0),
      mk_row(40000, 0, 0),
      // largest sums with no spread, then spread rows for the predictor
      mk_row(65535, 1, 0),
      mk_row(65535, 0, 1, 2, 65535, 0,     65535, 0),
      mk_row(32768, 0, 0),
      mk_row(43690, 1, 0),
      mk_row(21845, 0, 0)
    };

    // predictor starts from reset
    trk_nodes  = 0;
    trk_sum    = 0;
    trk_sq     = 0;
    scatter_q  = SCATTER_RST;
    min_test_q = MIN_TEST_RST;
    keep_q     = KEEP_RST;

    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    for (i = 0; i < NUM_DIR; i++)
      offer_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      // drain before touching the registers
      in_valid = 1'b0;
      wait (pending_stats.size() == 0);
      @(negedge clk);

      case (ph)
        0: begin scat = '0; mint = '0; keep = '0; end
        1: begin scat = '1; mint = '1; keep = '1; end
        2: begin scat = '1; mint = '0; keep = '0; end
        3: begin scat = '0; mint = '1; keep = '1; end
        NUM_PHASES - 1: begin
          scat = SCATTER_RST; mint = MIN_TEST_RST; keep = KEEP_RST;
        end
        default: begin
          scat = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535))
                                             : 16'($urandom_range(200, 6000));
          mint = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                             : 16'($urandom_range(0, 300));
          keep = 16'($urandom_range(0, 65535));
        end
      endcase
      write_reg(CFG_SCATTER,  scat);
      write_reg(CFG_MIN_TEST, mint);
      write_reg(CFG_KEEP,     keep);
      write_reg(CFG_SPARE,    16'($urandom_range(0, 65535)));
      cfg_write = 1'b0;

      // phase 1: no idling at all; phase 2: long hold-off at the output
      // with the sender pushing flat out, so the block backs up
      src_calm  = (ph == 1) || (ph == 2) || ($urandom_range(0, 3) == 0);
      sink_calm = (ph == 1) || ($urandom_range(0, 3) == 0);
      if (ph == 2) squeeze_req = 1'b1;

      for (i = 0; i < PHASE_ITEMS; i++)
        offer_item(next_track_item(), 1'b0, none);
    end

    in_valid = 1'b0;
    wait (pending_stats.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/tars_pkg.sv
sv/tars_mac.sv
sv/tars_div.sv
sv/tars_sqrt.sv
sv/track_angle_running_statistics.sv
tb/sv/tb_track_angle_running_statistics.sv
